/* design/psg_pkg.sv */
// Shared types, constants and register codes of the palette sweep pixel gradient unit.
// Depends on nothing; every other design file refers to it by scoped names.
package psg_pkg;

  localparam int unsigned MaxColors      = 6;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned DataW          = 32;
  localparam int unsigned TimeW          = 32;
  localparam int unsigned PeriodW        = 16;
  localparam int unsigned CycleW         = 19;
  localparam int unsigned SlotW          = 3;
  localparam int unsigned PalIdxW        = $clog2(MaxColors);
  localparam int unsigned ChanW          = 8;
  localparam int unsigned NumChan        = 4;
  localparam int unsigned ProdW          = ChanW + PeriodW;
  localparam int unsigned PixW           = 8;
  localparam int unsigned BufW           = PixW + 1;
  localparam int unsigned RemBitsPerStage = 2;
  localparam int unsigned RemStages      = TimeW / RemBitsPerStage;
  localparam int unsigned QBitsPerStage  = 2;
  localparam int unsigned QStages        = ChanW / QBitsPerStage;

  localparam logic [SlotW-1:0]   NumColorsReset  = 3'd2;
  localparam logic [PeriodW-1:0] MsPerColorReset = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    RegNumColors,
    RegMsPerColor,
    RegPalette0,
    RegPalette1,
    RegPalette2,
    RegPalette3,
    RegPalette4,
    RegPalette5
  } reg_idx_e;

  typedef struct packed {
    logic [SlotW-1:0]                    n;
    logic [PeriodW-1:0]                  period;
    logic [CycleW-1:0]                   cycle;
    logic [MaxColors-1:0][CycleW-1:0]    mult;
    logic [MaxColors-1:0][DataW-1:0]     palette;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] start;
    logic [PixW-1:0] pix;
    logic            last;
  } pix_t;

  typedef struct packed {
    logic [CycleW-1:0] rem;
    pix_t              px;
  } rem_t;

  typedef struct packed {
    logic [NumChan-1:0][ProdW-1:0] num;
    logic [NumChan-1:0][ChanW-1:0] base;
    logic [BufW-1:0]               bufidx;
    logic                          last;
  } qd_t;

  typedef struct packed {
    logic [BufW-1:0]               bufidx;
    logic [NumChan-1:0][ChanW-1:0] chan;
    logic                          last;
  } px_out_t;

endpackage

/* design/palette_sweep_pixel_gradient_unit.sv */
// Top level of the palette sweep pixel gradient unit: ports, configuration and the pipeline.
// Depends on psg_pkg, psg_cfg, psg_rem, psg_blend and psg_qdiv.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------------
//   input    | in_valid_i / in_stall_o    | now_ms_i, strip_start_i, pixel_index_i, last_pixel_i
//   output   | out_valid_o / out_stall_i  | buffer_index_o, red_o .. white_o, last_pixel_out_o
//   config   | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One transaction is accepted per cycle while the pipeline is not stalled. A result passes
// through an input register, the 16-stage remainder pipeline, three blend stages, four
// quotient stages and the output register. Every stage holds its own valid bit, so bubbles
// close up under a stall and nothing is lost or repeated. Reset clears the valid bits and
// loads the register defaults; derived period multiples follow a write in the cycle after it.
module palette_sweep_pixel_gradient_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [psg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [psg_pkg::DataW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [psg_pkg::TimeW-1:0]    now_ms_i,
  input  logic [psg_pkg::PixW-1:0]     strip_start_i,
  input  logic [psg_pkg::PixW-1:0]     pixel_index_i,
  input  logic                         last_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [psg_pkg::BufW-1:0]     buffer_index_o,
  output logic [psg_pkg::ChanW-1:0]    red_o,
  output logic [psg_pkg::ChanW-1:0]    green_o,
  output logic [psg_pkg::ChanW-1:0]    blue_o,
  output logic [psg_pkg::ChanW-1:0]    white_o,
  output logic                         last_pixel_out_o
);

  psg_pkg::cfg_t     cfg;
  psg_pkg::pix_t     px;
  psg_pkg::rem_t     rem;
  psg_pkg::qd_t      qd;
  psg_pkg::px_out_t  px_out;
  logic              in_ready;
  logic              rem_valid, rem_ready;
  logic              qd_valid, qd_ready;

  assign px.start = strip_start_i;
  assign px.pix   = pixel_index_i;
  assign px.last  = last_pixel_i;

  psg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  psg_rem u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .now_i       (now_ms_i),
    .px_i        (px),
    .out_valid_o (rem_valid),
    .out_ready_i (rem_ready),
    .out_o       (rem)
  );

  psg_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (rem_valid),
    .in_ready_o  (rem_ready),
    .in_i        (rem),
    .out_valid_o (qd_valid),
    .out_ready_i (qd_ready),
    .out_o       (qd)
  );

  psg_qdiv u_qdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (qd_valid),
    .in_ready_o  (qd_ready),
    .in_i        (qd),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_o       (px_out)
  );

  assign in_stall_o       = !in_ready;
  assign buffer_index_o   = px_out.bufidx;
  assign red_o            = px_out.chan[0];
  assign green_o          = px_out.chan[1];
  assign blue_o           = px_out.chan[2];
  assign white_o          = px_out.chan[3];
  assign last_pixel_out_o = px_out.last;

endmodule

/* design/psg_cfg.sv */
// Configuration registers of the gradient unit and the values derived from them.
// Depends on psg_pkg.
module psg_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [psg_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [psg_pkg::DataW-1:0]    data_i,
  output psg_pkg::cfg_t                cfg_o
);

  logic [psg_pkg::SlotW-1:0]                                 n_q;
  logic [psg_pkg::PeriodW-1:0]                               period_q;
  logic [psg_pkg::MaxColors-1:0][psg_pkg::DataW-1:0]         pal_q;
  logic [psg_pkg::CycleW-1:0]                                cycle_q, cycle_d;
  logic [psg_pkg::MaxColors-1:0][psg_pkg::CycleW-1:0]        mult_q, mult_d;
  logic [psg_pkg::SlotW-1:0]                                 n_eff;
  logic [psg_pkg::PeriodW-1:0]                               period_eff;
  logic [psg_pkg::PalIdxW-1:0]                               pidx;

  always_comb begin
    n_eff = n_q;
    if (n_q == '0) begin
      n_eff = psg_pkg::SlotW'(1);
    end else if (n_q > psg_pkg::SlotW'(psg_pkg::MaxColors)) begin
      n_eff = psg_pkg::SlotW'(psg_pkg::MaxColors);
    end
    period_eff = (period_q == '0) ? psg_pkg::PeriodW'(1) : period_q;
    cycle_d = psg_pkg::CycleW'(n_eff) * psg_pkg::CycleW'(period_eff);
    for (int k = 0; k < psg_pkg::MaxColors; k++) begin
      mult_d[k] = psg_pkg::CycleW'(k) * psg_pkg::CycleW'(period_eff);
    end
    pidx = psg_pkg::PalIdxW'(idx_i - psg_pkg::CfgIdxW'(psg_pkg::RegPalette0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= psg_pkg::NumColorsReset;
      period_q <= psg_pkg::MsPerColorReset;
      pal_q    <= '0;
    end else if (we_i) begin
      case (psg_pkg::reg_idx_e'(idx_i))
        psg_pkg::RegNumColors: begin
          n_q <= data_i[psg_pkg::SlotW-1:0];
        end
        psg_pkg::RegMsPerColor: begin
          period_q <= data_i[psg_pkg::PeriodW-1:0];
        end
        default: begin
          if (idx_i inside {[psg_pkg::RegPalette0:psg_pkg::RegPalette5]}) begin
            pal_q[pidx] <= data_i;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= psg_pkg::CycleW'(psg_pkg::NumColorsReset) *
                 psg_pkg::CycleW'(psg_pkg::MsPerColorReset);
      for (int k = 0; k < psg_pkg::MaxColors; k++) begin
        mult_q[k] <= psg_pkg::CycleW'(k) * psg_pkg::CycleW'(psg_pkg::MsPerColorReset);
      end
    end else begin
      cycle_q <= cycle_d;
      mult_q  <= mult_d;
    end
  end

  assign cfg_o.n       = n_eff;
  assign cfg_o.period  = period_eff;
  assign cfg_o.cycle   = cycle_q;
  assign cfg_o.mult    = mult_q;
  assign cfg_o.palette = pal_q;

endmodule

/* design/psg_rem.sv */
// Pipelined restoring remainder of the time stamp by the full palette cycle, two bits a stage.
// Depends on psg_pkg.
module psg_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  psg_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [psg_pkg::TimeW-1:0]  now_i,
  input  psg_pkg::pix_t              px_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output psg_pkg::rem_t              out_o
);

  typedef struct packed {
    logic [psg_pkg::CycleW-1:0] r;
    logic [psg_pkg::TimeW-1:0]  t;
    psg_pkg::pix_t              px;
  } rs_t;

  function automatic rs_t rem_stage(input rs_t s_in, input logic [psg_pkg::CycleW-1:0] d);
    rs_t                      r;
    logic [psg_pkg::CycleW:0] acc;
    r = s_in;
    for (int b = 0; b < psg_pkg::RemBitsPerStage; b++) begin
      acc = {r.r, r.t[psg_pkg::TimeW-1]};
      if (acc >= {1'b0, d}) begin
        acc = acc - {1'b0, d};
      end
      r.r = acc[psg_pkg::CycleW-1:0];
      r.t = {r.t[psg_pkg::TimeW-2:0], 1'b0};
    end
    return r;
  endfunction

  rs_t                          st_q [0:psg_pkg::RemStages];
  logic [psg_pkg::RemStages:0]  v_q;
  logic [psg_pkg::RemStages:0]  adv;

  always_comb begin
    adv[psg_pkg::RemStages] = !v_q[psg_pkg::RemStages] || out_ready_i;
    for (int k = psg_pkg::RemStages - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= psg_pkg::RemStages; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      st_q[0].r  <= '0;
      st_q[0].t  <= now_i;
      st_q[0].px <= px_i;
    end
    for (int k = 1; k <= psg_pkg::RemStages; k++) begin
      if (adv[k] && v_q[k-1]) begin
        st_q[k] <= rem_stage(st_q[k-1], cfg_i.cycle);
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[psg_pkg::RemStages];
  assign out_o.rem   = st_q[psg_pkg::RemStages].r;
  assign out_o.px    = st_q[psg_pkg::RemStages].px;

endmodule

/* design/psg_blend.sv */
// Slot, phase and palette selection, then the per-channel blend products, in three stages.
// Depends on psg_pkg.
module psg_blend (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psg_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  psg_pkg::rem_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output psg_pkg::qd_t   out_o
);

  typedef struct packed {
    logic [psg_pkg::SlotW-1:0]   slot;
    logic [psg_pkg::PeriodW-1:0] phase;
    logic [psg_pkg::SlotW-1:0]   pm;
    logic [psg_pkg::BufW-1:0]    bufidx;
    logic                        last;
  } b1_t;

  typedef struct packed {
    logic [psg_pkg::NumChan-1:0][psg_pkg::ChanW-1:0]   diff;
    logic [psg_pkg::NumChan-1:0][psg_pkg::PeriodW-1:0] fac;
    logic [psg_pkg::NumChan-1:0][psg_pkg::ChanW-1:0]   base;
    logic [psg_pkg::BufW-1:0]                          bufidx;
    logic                                              last;
  } b2_t;

  function automatic logic [psg_pkg::SlotW-1:0] mod_n(input logic [psg_pkg::PixW-1:0] v,
                                                      input logic [psg_pkg::SlotW-1:0] n);
    logic [psg_pkg::SlotW:0]   acc;
    logic [psg_pkg::SlotW-1:0] r;
    r = '0;
    for (int i = psg_pkg::PixW - 1; i >= 0; i--) begin
      acc = {r, v[i]};
      if (acc >= {1'b0, n}) begin
        acc = acc - {1'b0, n};
      end
      r = acc[psg_pkg::SlotW-1:0];
    end
    return r;
  endfunction

  b1_t           b1_q, b1_d;
  b2_t           b2_q, b2_d;
  psg_pkg::qd_t  b3_q, b3_d;
  logic [2:0]    v_q;
  logic [2:0]    adv;

  always_comb begin
    adv[2] = !v_q[2] || out_ready_i;
    adv[1] = !v_q[1] || adv[2];
    adv[0] = !v_q[0] || adv[1];
  end

  always_comb begin
    b1_d.slot = '0;
    for (int k = 1; k < psg_pkg::MaxColors; k++) begin
      if (in_i.rem >= cfg_i.mult[k]) begin
        b1_d.slot = psg_pkg::SlotW'(k);
      end
    end
    b1_d.phase  = psg_pkg::PeriodW'(in_i.rem - cfg_i.mult[b1_d.slot]);
    b1_d.pm     = mod_n(in_i.px.pix, cfg_i.n);
    b1_d.bufidx = psg_pkg::BufW'(in_i.px.start) + psg_pkg::BufW'(in_i.px.pix);
    b1_d.last   = in_i.px.last;
  end

  always_comb begin
    logic [psg_pkg::SlotW:0]     sum;
    logic [psg_pkg::PalIdxW-1:0] ia;
    logic [psg_pkg::PalIdxW-1:0] ib;
    logic [psg_pkg::DataW-1:0]   ca;
    logic [psg_pkg::DataW-1:0]   cb;
    logic [psg_pkg::ChanW-1:0]   a;
    logic [psg_pkg::ChanW-1:0]   b;
    sum = {1'b0, b1_q.slot} + {1'b0, b1_q.pm};
    if (sum >= {1'b0, cfg_i.n}) begin
      sum = sum - {1'b0, cfg_i.n};
    end
    ia = psg_pkg::PalIdxW'(sum);
    if ((psg_pkg::SlotW+1)'(ia) + (psg_pkg::SlotW+1)'(1) == {1'b0, cfg_i.n}) begin
      ib = '0;
    end else begin
      ib = ia + psg_pkg::PalIdxW'(1);
    end
    ca = cfg_i.palette[ia];
    cb = cfg_i.palette[ib];
    for (int c = 0; c < psg_pkg::NumChan; c++) begin
      a = ca[c*psg_pkg::ChanW +: psg_pkg::ChanW];
      b = cb[c*psg_pkg::ChanW +: psg_pkg::ChanW];
      if (a > b) begin
        b2_d.diff[c] = a - b;
        b2_d.fac[c]  = cfg_i.period - b1_q.phase;
        b2_d.base[c] = b;
      end else begin
        b2_d.diff[c] = b - a;
        b2_d.fac[c]  = b1_q.phase;
        b2_d.base[c] = a;
      end
    end
    b2_d.bufidx = b1_q.bufidx;
    b2_d.last   = b1_q.last;
  end

  always_comb begin
    for (int c = 0; c < psg_pkg::NumChan; c++) begin
      b3_d.num[c] = psg_pkg::ProdW'(b2_q.diff[c]) * psg_pkg::ProdW'(b2_q.fac[c]);
    end
    b3_d.base   = b2_q.base;
    b3_d.bufidx = b2_q.bufidx;
    b3_d.last   = b2_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (adv[1]) begin
        v_q[1] <= v_q[0];
      end
      if (adv[2]) begin
        v_q[2] <= v_q[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      b1_q <= b1_d;
    end
    if (adv[1] && v_q[0]) begin
      b2_q <= b2_d;
    end
    if (adv[2] && v_q[1]) begin
      b3_q <= b3_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[2];
  assign out_o       = b3_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) v_q[0] |-> b1_q.slot < cfg_i.n)
    else $error("Palette slot is not below the colour count.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) v_q[0] |-> b1_q.phase < cfg_i.period)
    else $error("Phase is not below the period.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) v_q[0] |-> b1_q.pm < cfg_i.n)
    else $error("Pixel offset is not reduced below the colour count.");

endmodule

/* design/psg_qdiv.sv */
// Pipelined restoring division of the blend products by the period and the final channel sums.
// Depends on psg_pkg.
module psg_qdiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psg_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  psg_pkg::qd_t                 in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output psg_pkg::px_out_t             out_o
);

  typedef struct packed {
    logic [psg_pkg::NumChan-1:0][psg_pkg::ProdW-1:0] rem;
    logic [psg_pkg::NumChan-1:0][psg_pkg::ChanW-1:0] q;
    logic [psg_pkg::NumChan-1:0][psg_pkg::ChanW-1:0] base;
    logic [psg_pkg::BufW-1:0]                        bufidx;
    logic                                            last;
  } qs_t;

  function automatic qs_t qd_stage(input qs_t s_in, input int unsigned s,
                                   input logic [psg_pkg::PeriodW-1:0] p);
    qs_t                       r;
    logic [psg_pkg::ProdW-1:0] d;
    int unsigned               j;
    r = s_in;
    for (int c = 0; c < psg_pkg::NumChan; c++) begin
      for (int unsigned b = 0; b < psg_pkg::QBitsPerStage; b++) begin
        j = psg_pkg::ChanW - 1 - s * psg_pkg::QBitsPerStage - b;
        d = psg_pkg::ProdW'(p) << j;
        if (r.rem[c] >= d) begin
          r.rem[c] = r.rem[c] - d;
          r.q[c]   = {r.q[c][psg_pkg::ChanW-2:0], 1'b1};
        end else begin
          r.q[c]   = {r.q[c][psg_pkg::ChanW-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  qs_t                        st_q [0:psg_pkg::QStages-1];
  qs_t                        nxt  [0:psg_pkg::QStages-1];
  qs_t                        init;
  psg_pkg::px_out_t           out_q, out_d;
  logic [psg_pkg::QStages:0]  v_q;
  logic [psg_pkg::QStages:0]  adv;
  logic                       rem_ok, num_ok, carry_any;
  logic [psg_pkg::ChanW:0]    sum_chk;

  always_comb begin
    adv[psg_pkg::QStages] = !v_q[psg_pkg::QStages] || out_ready_i;
    for (int k = psg_pkg::QStages - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_comb begin
    init.rem    = in_i.num;
    init.q      = '0;
    init.base   = in_i.base;
    init.bufidx = in_i.bufidx;
    init.last   = in_i.last;
    nxt[0] = qd_stage(init, 0, cfg_i.period);
    for (int unsigned s = 1; s < psg_pkg::QStages; s++) begin
      nxt[s] = qd_stage(st_q[s-1], s, cfg_i.period);
    end
    for (int c = 0; c < psg_pkg::NumChan; c++) begin
      out_d.chan[c] = st_q[psg_pkg::QStages-1].base[c] + st_q[psg_pkg::QStages-1].q[c];
    end
    out_d.bufidx = st_q[psg_pkg::QStages-1].bufidx;
    out_d.last   = st_q[psg_pkg::QStages-1].last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= psg_pkg::QStages; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      st_q[0] <= nxt[0];
    end
    for (int k = 1; k < psg_pkg::QStages; k++) begin
      if (adv[k] && v_q[k-1]) begin
        st_q[k] <= nxt[k];
      end
    end
    if (adv[psg_pkg::QStages] && v_q[psg_pkg::QStages-1]) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[psg_pkg::QStages];
  assign out_o       = out_q;

  always_comb begin
    rem_ok    = 1'b1;
    num_ok    = 1'b1;
    carry_any = 1'b0;
    sum_chk   = '0;
    for (int c = 0; c < psg_pkg::NumChan; c++) begin
      if (st_q[psg_pkg::QStages-1].rem[c] >= psg_pkg::ProdW'(cfg_i.period)) begin
        rem_ok = 1'b0;
      end
      if (in_i.num[c] >= (psg_pkg::ProdW'(cfg_i.period) << psg_pkg::ChanW)) begin
        num_ok = 1'b0;
      end
      sum_chk = {1'b0, st_q[psg_pkg::QStages-1].base[c]} +
                {1'b0, st_q[psg_pkg::QStages-1].q[c]};
      if (sum_chk[psg_pkg::ChanW]) begin
        carry_any = 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_valid_i |-> num_ok)
    else $error("Blend product does not give an eight-bit quotient.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) v_q[psg_pkg::QStages-1] |-> rem_ok)
    else $error("Division remainder is not below the period.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   v_q[psg_pkg::QStages-1] |-> !carry_any)
    else $error("Channel sum overflows eight bits.");

endmodule

/* sim/tb_palette_sweep_pixel_gradient_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for palette_sweep_pixel_gradient_unit: directed corners, random
// palettes and timings, back-pressure and full-rate traffic, checked against a local predictor.
// Depends on psg_pkg and the design files of the unit.
module tb_palette_sweep_pixel_gradient_unit;

  localparam int unsigned HalfPeriod    = 6;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 40;

  typedef struct packed {
    logic [psg_pkg::BufW-1:0]  bufidx;
    logic [psg_pkg::ChanW-1:0] red;
    logic [psg_pkg::ChanW-1:0] green;
    logic [psg_pkg::ChanW-1:0] blue;
    logic [psg_pkg::ChanW-1:0] white;
    logic                      last;
  } pixel_res_t;

  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         cfg_we_i         = 1'b0;
  logic [psg_pkg::CfgIdxW-1:0]  cfg_idx_i        = '0;
  logic [psg_pkg::DataW-1:0]    cfg_data_i       = '0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_stall_o;
  logic [psg_pkg::TimeW-1:0]    now_ms_i         = '0;
  logic [psg_pkg::PixW-1:0]     strip_start_i    = '0;
  logic [psg_pkg::PixW-1:0]     pixel_index_i    = '0;
  logic                         last_pixel_i     = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i      = 1'b0;
  logic [psg_pkg::BufW-1:0]     buffer_index_o;
  logic [psg_pkg::ChanW-1:0]    red_o;
  logic [psg_pkg::ChanW-1:0]    green_o;
  logic [psg_pkg::ChanW-1:0]    blue_o;
  logic [psg_pkg::ChanW-1:0]    white_o;
  logic                         last_pixel_out_o;

  logic [psg_pkg::SlotW-1:0]    shadow_colors;
  logic [psg_pkg::PeriodW-1:0]  shadow_period;
  logic [psg_pkg::DataW-1:0]    shadow_palette [psg_pkg::MaxColors];

  pixel_res_t          pixels_due [$];
  int unsigned         mismatch_count = 0;
  bit                  tx_idle_en     = 1'b1;
  bit                  rx_idle_en     = 1'b1;
  int unsigned         rx_hold_left   = 0;

  palette_sweep_pixel_gradient_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .now_ms_i         (now_ms_i),
    .strip_start_i    (strip_start_i),
    .pixel_index_i    (pixel_index_i),
    .last_pixel_i     (last_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .buffer_index_o   (buffer_index_o),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o),
    .white_o          (white_o),
    .last_pixel_out_o (last_pixel_out_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  function automatic logic [psg_pkg::ChanW-1:0] blend_level(logic [psg_pkg::ChanW-1:0] a,
                                                            logic [psg_pkg::ChanW-1:0] b,
                                                            int unsigned phase,
                                                            int unsigned period);
    longint unsigned num;
    if (a > b) begin
      num = 64'(period - phase);
      num = num * (a - b);
      return psg_pkg::ChanW'(b + num / period);
    end
    num = 64'(phase);
    num = num * (b - a);
    return psg_pkg::ChanW'(a + num / period);
  endfunction

  function automatic pixel_res_t blend_pixel(logic [psg_pkg::TimeW-1:0] now,
                                             logic [psg_pkg::PixW-1:0] start,
                                             logic [psg_pkg::PixW-1:0] pix, logic last);
    int unsigned n;
    int unsigned period;
    int unsigned cycle;
    int unsigned rem;
    int unsigned slot;
    int unsigned phase;
    logic [psg_pkg::DataW-1:0] ca;
    logic [psg_pkg::DataW-1:0] cb;
    pixel_res_t r;
    n = 32'(shadow_colors);
    if (n == 0) n = 1;
    if (n > psg_pkg::MaxColors) n = psg_pkg::MaxColors;
    period = (shadow_period == 0) ? 1 : 32'(shadow_period);
    cycle = n * period;
    rem = now % cycle;
    slot = rem / period;
    phase = rem - slot * period;
    ca = shadow_palette[(slot + pix) % n];
    cb = shadow_palette[(slot + pix + 1) % n];
    r.bufidx = {1'b0, start} + {1'b0, pix};
    r.red    = blend_level(ca[7:0],   cb[7:0],   phase, period);
    r.green  = blend_level(ca[15:8],  cb[15:8],  phase, period);
    r.blue   = blend_level(ca[23:16], cb[23:16], phase, period);
    r.white  = blend_level(ca[31:24], cb[31:24], phase, period);
    r.last   = last;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Result checker: every accepted output transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin
    pixel_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result at buffer index %0d", buffer_index_o));
      end else begin
        want = pixels_due.pop_front();
        check_field("buffer_index", 32'(buffer_index_o), 32'(want.bufidx));
        check_field("red", 32'(red_o), 32'(want.red));
        check_field("green", 32'(green_o), 32'(want.green));
        check_field("blue", 32'(blue_o), 32'(want.blue));
        check_field("white", 32'(white_o), 32'(want.white));
        check_field("last_pixel_out", 32'(last_pixel_out_o), 32'(want.last));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_stall_i <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_stall_i <= rx_idle_en && ($urandom_range(99) < 20);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(psg_pkg::reg_idx_e idx, logic [psg_pkg::DataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      psg_pkg::RegNumColors:  shadow_colors = data[psg_pkg::SlotW-1:0];
      psg_pkg::RegMsPerColor: shadow_period = data[psg_pkg::PeriodW-1:0];
      default:                shadow_palette[idx - psg_pkg::RegPalette0] = data;
    endcase
    @(negedge clk_i);
  endtask

  // The derived period multiples follow a write in the cycle after it, so allow them to settle.
  task automatic end_config();
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= psg_pkg::CfgIdxW'($urandom);
    cfg_data_i <= $urandom;
    @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_pixel(logic [psg_pkg::TimeW-1:0] now, logic [psg_pkg::PixW-1:0] start,
                            logic [psg_pkg::PixW-1:0] pix, logic last);
    pixel_res_t want;
    want = blend_pixel(now, start, pix, last);
    while (tx_idle_en && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    now_ms_i      <= now;
    strip_start_i <= start;
    pixel_index_i <= pix;
    last_pixel_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_due.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic stop_offering();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pixels_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_segment(logic [psg_pkg::TimeW-1:0] now, logic [psg_pkg::PixW-1:0] start,
                              int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_pixel(now, start, psg_pkg::PixW'(k), k == len - 1);
    end
  endtask

  task automatic random_config();
    logic [psg_pkg::PeriodW-1:0] period;
    case ($urandom_range(5))
      0:       period = psg_pkg::PeriodW'($urandom_range(0, 3));
      1:       period = psg_pkg::PeriodW'($urandom_range(1, 20));
      2:       period = '1;
      3:       period = psg_pkg::PeriodW'($urandom);
      default: period = psg_pkg::PeriodW'($urandom_range(100, 2000));
    endcase
    write_reg(psg_pkg::RegNumColors, {29'($urandom), 3'($urandom_range(0, 7))});
    write_reg(psg_pkg::RegMsPerColor, {16'($urandom), period});
    for (int i = 0; i < psg_pkg::MaxColors; i++) begin
      case ($urandom_range(5))
        0:       write_reg(psg_pkg::reg_idx_e'(psg_pkg::RegPalette0 + i), '0);
        1:       write_reg(psg_pkg::reg_idx_e'(psg_pkg::RegPalette0 + i), '1);
        default: write_reg(psg_pkg::reg_idx_e'(psg_pkg::RegPalette0 + i), $urandom);
      endcase
    end
    end_config();
  endtask

  // Mostly whole segments sharing one frame time, with some stray pixels in between.
  task automatic random_traffic(int unsigned items);
    int unsigned sent;
    int unsigned len;
    logic [psg_pkg::TimeW-1:0] now;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(3))
        0:       now = $urandom_range(0, 400000);
        1:       now = '1 - $urandom_range(0, 1000);
        default: now = $urandom;
      endcase
      if ($urandom_range(3) != 0) begin
        len = $urandom_range(1, 12);
        send_segment(now, psg_pkg::PixW'($urandom), len);
        sent += len;
      end else begin
        send_pixel(now, psg_pkg::PixW'($urandom), psg_pkg::PixW'($urandom), 1'($urandom));
        sent++;
      end
    end
    stop_offering();
    wait_drained();
  endtask

  task automatic test_reset_defaults();
    send_pixel('0, '0, '0, 1'b0);
    send_pixel('1, '1, '1, 1'b1);
    send_pixel(32'd1500, 8'd17, 8'd3, 1'b0);
    stop_offering();
    wait_drained();
  endtask

  task automatic test_blend_corners();
    write_reg(psg_pkg::RegNumColors, 32'd3);
    write_reg(psg_pkg::RegMsPerColor, 32'd1000);
    write_reg(psg_pkg::RegPalette0, 32'h00FF40C0);
    write_reg(psg_pkg::RegPalette1, 32'hFF00C040);
    write_reg(psg_pkg::RegPalette2, 32'h80808080);
    end_config();
    send_pixel(32'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(32'd999, 8'd0, 8'd1, 1'b0);
    send_pixel(32'd1000, 8'd10, 8'd2, 1'b0);
    send_pixel(32'd2999, 8'd200, 8'd200, 1'b0);
    send_pixel(32'd3000, 8'd255, 8'd0, 1'b1);
    send_pixel(32'd1234567, 8'd128, 8'd127, 1'b1);
    stop_offering();
    wait_drained();
  endtask

  // Single colour, zero colours, too many colours and a zero period.
  task automatic test_colour_limits();
    write_reg(psg_pkg::RegNumColors, 32'd1);
    end_config();
    send_pixel(32'd500, 8'd1, 8'd5, 1'b0);
    send_pixel('1, 8'd2, 8'd255, 1'b1);
    stop_offering();
    wait_drained();
    write_reg(psg_pkg::RegNumColors, 32'hFFFFFFF8);
    end_config();
    send_pixel(32'd750, 8'd3, 8'd1, 1'b0);
    send_pixel(32'd12345, 8'd4, 8'd2, 1'b1);
    stop_offering();
    wait_drained();
    write_reg(psg_pkg::RegNumColors, 32'd7);
    write_reg(psg_pkg::RegMsPerColor, 32'h0000FFFF);
    write_reg(psg_pkg::RegPalette3, 32'hFFFFFFFF);
    write_reg(psg_pkg::RegPalette4, 32'h00000000);
    write_reg(psg_pkg::RegPalette5, 32'h01FE7F80);
    end_config();
    send_pixel('1, 8'd0, 8'd4, 1'b0);
    send_pixel(32'd393209, 8'd255, 8'd255, 1'b0);
    send_pixel(32'h7FFFFFFF, 8'd9, 8'd5, 1'b1);
    stop_offering();
    wait_drained();
    write_reg(psg_pkg::RegMsPerColor, 32'hABCD0000);
    end_config();
    send_pixel(32'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(32'd5, 8'd0, 8'd1, 1'b0);
    send_pixel('1, 8'd0, 8'd2, 1'b1);
    stop_offering();
    wait_drained();
  endtask

  task automatic test_random_sweeps();
    for (int i = 0; i < 5; i++) begin
      random_config();
      random_traffic(50);
    end
  endtask

  task automatic test_output_holdoff();
    random_config();
    tx_idle_en = 1'b0;
    rx_hold_left = HoldCycles;
    random_traffic(60);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_input_pause();
    random_config();
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 20; k++) begin
        send_pixel($urandom, psg_pkg::PixW'($urandom), psg_pkg::PixW'(k), k == 19);
      end
      stop_offering();
      wait_drained();
    end
  endtask

  task automatic test_full_rate();
    random_config();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_traffic(80);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    shadow_colors = psg_pkg::NumColorsReset;
    shadow_period = psg_pkg::MsPerColorReset;
    for (int i = 0; i < psg_pkg::MaxColors; i++) shadow_palette[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_blend_corners();
    test_colour_limits();
    test_random_sweeps();
    test_output_holdoff();
    test_input_pause();
    test_full_rate();
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pixels_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
